// File: src/rms_level_meter_unit_macros.svh
// Assertion helpers for the meter's RTL; only the controller includes this file.
`ifndef RMS_LEVEL_METER_UNIT_MACROS_SVH
`define RMS_LEVEL_METER_UNIT_MACROS_SVH

// Checked at every edge outside of reset.
`define RMSLM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define RMSLM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/rmslm_pkg.sv
package rmslm_pkg;

   localparam int MAX_CHUNK = 4096;

   localparam int SAMPLE_W  = 16;
   localparam int SQUARE_W  = 2 * SAMPLE_W;
   localparam int CNT_W     = $clog2(MAX_CHUNK + 1);
   localparam int SUM_W     = 2 * SAMPLE_W - 1 + $clog2(MAX_CHUNK);
   localparam int DREM_W    = $clog2(MAX_CHUNK);
   localparam int LEVEL_W   = 17;
   localparam int COEF_W    = 16;

   localparam int SQ_X_W    = 34;
   localparam int SQ_ROOT_W = SQ_X_W / 2;
   localparam int SQ_REM_W  = SQ_ROOT_W + 3;
   localparam int SQ_STEPS  = SQ_X_W / 2;
   localparam int DIV_STEPS = SUM_W;
   localparam int ITER_W    = $clog2(DIV_STEPS + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR = 2'd2;

   localparam logic [COEF_W-1:0]  GAIN_RESET  = 16'd22118;
   localparam logic [COEF_W-1:0]  DECAY_RESET = 16'd53739;
   localparam logic [LEVEL_W-1:0] FLOOR_RESET = 17'd262;
   localparam logic [LEVEL_W-1:0] FULL_SCALE  = 17'd65536;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   typedef struct packed {
      logic accum;
      logic div_init;
      logic div_step;
      logic sq_load1;
      logic sq_step;
      logic sq_load2;
      logic scale;
      logic update;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic count_last;
      logic out_free;
   } status_type;

endpackage

// File: src/rmslm_datapath.sv
module rmslm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rmslm_pkg::cmd_type                  cmd,
   output rmslm_pkg::status_type               status,
   input  logic signed [rmslm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                csr_write,
   input  logic [rmslm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rmslm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rmslm_pkg::LEVEL_W-1:0]       rsp_level
);
   import rmslm_pkg::*;

   logic [COEF_W-1:0]    gain_ff, gain_in;
   logic [COEF_W-1:0]    decay_ff, decay_in;
   logic [LEVEL_W-1:0]   floor_ff, floor_in;

   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DREM_W-1:0]    drem_ff, drem_in;
   logic [SQ_X_W-1:0]    sqx_ff, sqx_in;
   logic [SQ_REM_W-1:0]  sqrem_ff, sqrem_in;
   logic [SQ_ROOT_W-1:0] root_ff, root_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [LEVEL_W-1:0]   decayed_ff, decayed_in;
   logic [LEVEL_W-1:0]   meter_ff, meter_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   logic [SAMPLE_W-1:0]  mag;
   logic [SQUARE_W-1:0]  square;
   logic [DREM_W:0]      div_shift;
   logic [DREM_W:0]      div_n;
   logic                 div_bit;
   logic [SQ_REM_W-1:0]  sq_shift;
   logic [SQ_REM_W-1:0]  sq_trial;
   logic                 sq_bit;
   logic [SQ_ROOT_W+COEF_W-1:0] gain_prod;
   logic [LEVEL_W+COEF_W-1:0]   decay_prod;
   logic [SQ_ROOT_W+COEF_W-15:0] scaled;
   logic [LEVEL_W-1:0]   ballistic;

   assign mag    = req_sample[SAMPLE_W-1] ? SAMPLE_W'(-req_sample) : SAMPLE_W'(req_sample);
   assign square = mag * mag;

   assign div_shift = {drem_ff, sum_ff[SUM_W-1]};
   assign div_n     = (DREM_W+1)'(count_ff);
   assign div_bit   = (div_shift >= div_n);

   assign sq_shift = {sqrem_ff[SQ_REM_W-3:0], sqx_ff[SQ_X_W-1:SQ_X_W-2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_bit   = (sq_shift >= sq_trial);

   assign gain_prod  = root_ff * gain_ff;
   assign decay_prod = meter_ff * decay_ff;
   assign scaled     = gain_prod[SQ_ROOT_W+COEF_W-1:14];

   always_comb begin
      ballistic = (level_ff > meter_ff) ? level_ff : decayed_ff;
      if (ballistic < floor_ff) begin
         ballistic = '0;
      end
   end

   always_comb begin
      gain_in  = gain_ff;
      decay_in = decay_ff;
      floor_in = floor_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN:  gain_in  = csr_wdata[COEF_W-1:0];
            CSR_DECAY: decay_in = csr_wdata[COEF_W-1:0];
            CSR_FLOOR: floor_in = csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      drem_in    = drem_ff;
      sqx_in     = sqx_ff;
      sqrem_in   = sqrem_ff;
      root_in    = root_ff;
      level_in   = level_ff;
      decayed_in = decayed_ff;
      meter_in   = meter_ff;
      rsp_level_in = rsp_level_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (cmd.accum) begin
         sum_in   = sum_ff + SUM_W'(square);
         count_in = count_ff + 1'b1;
      end
      if (cmd.div_init) begin
         drem_in = '0;
      end
      if (cmd.div_step) begin
         drem_in = div_bit ? DREM_W'(div_shift - div_n) : div_shift[DREM_W-1:0];
         sum_in  = {sum_ff[SUM_W-2:0], div_bit};
      end
      if (cmd.sq_load1) begin
         sqx_in   = sum_ff[SQ_X_W-1:0];
         sqrem_in = '0;
         root_in  = '0;
         sum_in   = '0;
         count_in = '0;
      end
      if (cmd.sq_step) begin
         sqx_in   = {sqx_ff[SQ_X_W-3:0], 2'b00};
         sqrem_in = sq_bit ? (sq_shift - sq_trial) : sq_shift;
         root_in  = {root_ff[SQ_ROOT_W-2:0], sq_bit};
      end
      if (cmd.sq_load2) begin
         sqx_in   = {1'b0, root_ff[SAMPLE_W-1:0], (SQ_X_W-SAMPLE_W-1)'(0)};
         sqrem_in = '0;
         root_in  = '0;
      end
      if (cmd.scale) begin
         level_in   = (scaled > (SQ_ROOT_W+COEF_W-14)'(FULL_SCALE)) ?
                      FULL_SCALE : scaled[LEVEL_W-1:0];
         decayed_in = decay_prod[LEVEL_W+COEF_W-1:COEF_W];
      end
      if (cmd.update) begin
         meter_in     = ballistic;
         rsp_level_in = ballistic;
         rsp_valid_in = 1'b1;
      end
      if (cmd.clear) begin
         meter_in = '0;
         if (meter_ff != '0) begin
            rsp_level_in = '0;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         decay_ff     <= DECAY_RESET;
         floor_ff     <= FLOOR_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         meter_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         decay_ff     <= decay_in;
         floor_ff     <= floor_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         meter_ff     <= meter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drem_ff      <= drem_in;
      sqx_ff       <= sqx_in;
      sqrem_ff     <= sqrem_in;
      root_ff      <= root_in;
      level_ff     <= level_in;
      decayed_ff   <= decayed_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign status.count_last = (count_ff == CNT_W'(MAX_CHUNK - 1));
   assign status.out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

endmodule

// File: src/rmslm_ctrl.sv
`include "rms_level_meter_unit_macros.svh"

module rmslm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic                  req_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rmslm_pkg::status_type status,
   output rmslm_pkg::cmd_type    cmd
);
   import rmslm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SQ1  = 3'd2;
   localparam logic [2:0] ST_SQ2  = 3'd3;
   localparam logic [2:0] ST_BALL = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              accept;

   assign req_stall = (state_ff != ST_IDLE) ||
                      ((req_type == REQ_CLEAR) && rsp_valid && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_CLEAR) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.accum = 1'b1;
                  if (req_last || status.count_last) begin
                     cmd.div_init = 1'b1;
                     iter_in      = '0;
                     state_in     = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (iter_ff == ITER_W'(DIV_STEPS)) begin
               cmd.sq_load1 = 1'b1;
               iter_in      = '0;
               state_in     = ST_SQ1;
            end else begin
               cmd.div_step = 1'b1;
               iter_in      = iter_ff + 1'b1;
            end
         end
         ST_SQ1: begin
            if (iter_ff == ITER_W'(SQ_STEPS)) begin
               cmd.sq_load2 = 1'b1;
               iter_in      = '0;
               state_in     = ST_SQ2;
            end else begin
               cmd.sq_step = 1'b1;
               iter_in     = iter_ff + 1'b1;
            end
         end
         ST_SQ2: begin
            if (iter_ff == ITER_W'(SQ_STEPS)) begin
               cmd.scale = 1'b1;
               state_in  = ST_BALL;
            end else begin
               cmd.sq_step = 1'b1;
               iter_in     = iter_ff + 1'b1;
            end
         end
         ST_BALL: begin
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   `RMSLM_ASSERT(a_busy_stalls, (state_ff != ST_IDLE) |-> req_stall, "input taken while busy")
   `RMSLM_ASSERT(a_ball_exit, (state_ff == ST_BALL && status.out_free) |=> (state_ff == ST_IDLE), "result not issued when output was free")
   `RMSLM_ASSERT(a_div_bound, (state_ff == ST_DIV) |-> (iter_ff <= ITER_W'(DIV_STEPS)), "divider ran past its last step")
   `RMSLM_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && iter_ff == '0), "controller not idle after reset")

endmodule

// File: src/rms_level_meter_unit.sv
// Channel   Handshake                   Payload
// req       req_valid / req_stall       req_type, req_sample, req_last
// rsp       rsp_valid / rsp_stall       rsp_level
// csr       csr_valid / csr_ready       csr_index, csr_wdata
//
// A sample that does not end a chunk is accumulated as it is taken, and the next may follow at once.
// A chunk end holds off the input through a 43-step shift-subtract divider,
// then two 17-step passes of one shared bit-pair square root unit, a gain and decay
// multiply, and the ballistics update, which waits for a free output slot.
// Reset is synchronous and restores the register defaults and a zero meter level.
// A stalled result holds the input only when a clear or a chunk end needs the output slot.
module rms_level_meter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic signed [rmslm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rmslm_pkg::LEVEL_W-1:0]         rsp_level,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rmslm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rmslm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rmslm_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rmslm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rmslm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_sample),
      .csr_write  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_level  (rsp_level)
   );

endmodule

// File: tb/tb_rms_level_meter_unit.sv
module tb_rms_level_meter_unit;
   import rmslm_pkg::*;

   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 1000000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_type;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_last;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [LEVEL_W-1:0]         rsp_level;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   rms_level_meter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_sample (req_sample),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_level  (rsp_level),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predicted block state and register copies.
   logic [COEF_W-1:0]  gain_q14;
   logic [COEF_W-1:0]  decay_q16;
   logic [LEVEL_W-1:0] floor_q16;
   logic [63:0]        square_total;
   int unsigned        chunk_fill;
   logic [LEVEL_W-1:0] meter;

   logic [LEVEL_W-1:0] level_expected[$];

   int  error_count;
   int  levels_checked;
   int  items_sent;
   int  chunk_ends;
   int  clears_sent;
   int  settings_used;
   int  sender_idle_pct;
   int  stall_pct;
   int  cycle_count;
   bit  valid_high;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out with %0d levels still expected.", level_expected.size());
         $display("tb_rms_level_meter_unit: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("Mismatch at cycle %0d, %s: got %0d, expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (level_expected.size() == 0) begin
            report_mismatch("level with no transaction pending", longint'(rsp_level), -1);
         end else begin
            if (rsp_level !== level_expected[0]) begin
               report_mismatch("rsp_level", longint'(rsp_level), longint'(level_expected[0]));
            end
            void'(level_expected.pop_front());
            levels_checked++;
         end
      end
   end

   function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= v) root = trial;
      end
      return root;
   endfunction

   function automatic logic [LEVEL_W-1:0] chunk_level_of(input logic [63:0] total,
                                                         input int unsigned count);
      logic [63:0] rms;
      logic [63:0] root;
      logic [63:0] scaled;
      rms = 64'(floor_sqrt(total / 64'(count)));
      root = 64'(floor_sqrt((rms * 2) << 16));
      scaled = (root * 64'(gain_q14)) >> 14;
      if (scaled > 64'(FULL_SCALE)) scaled = 64'(FULL_SCALE);
      return scaled[LEVEL_W-1:0];
   endfunction

   task automatic advance_meter(input logic kind, input logic signed [SAMPLE_W-1:0] smp,
                                input logic lst);
      int                 value;
      logic [63:0]        mag;
      logic [LEVEL_W-1:0] fresh;
      logic [63:0]        decayed;
      if (kind == REQ_CLEAR) begin
         clears_sent++;
         if (meter != 0) level_expected.push_back('0);
         meter = '0;
         return;
      end
      value = int'(smp);
      mag = 64'((value < 0) ? -value : value);
      square_total += mag * mag;
      chunk_fill++;
      if (!lst && chunk_fill < MAX_CHUNK) return;
      fresh = chunk_level_of(square_total, chunk_fill);
      square_total = '0;
      chunk_fill = 0;
      if (fresh > meter) begin
         meter = fresh;
      end else begin
         decayed = (64'(meter) * 64'(decay_q16)) >> 16;
         meter = decayed[LEVEL_W-1:0];
      end
      if (meter < floor_q16) meter = '0;
      level_expected.push_back(meter);
      chunk_ends++;
   endtask

   task automatic send_item(input logic kind, input logic signed [SAMPLE_W-1:0] smp,
                            input logic lst);
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample <= smp;
      req_last <= lst;
      valid_high = 1'b1;
      do @(posedge clock); while (req_stall);
      advance_meter(kind, smp, lst);
      items_sent++;
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         valid_high = 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   task automatic drain_results(input int settle);
      if (valid_high) begin
         req_valid <= 1'b0;
         valid_high = 1'b0;
      end
      do @(posedge clock); while (level_expected.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAIN: begin
            gain_q14 = data[COEF_W-1:0];
         end
         CSR_DECAY: begin
            decay_q16 = data[COEF_W-1:0];
         end
         CSR_FLOOR: begin
            floor_q16 = data[LEVEL_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_meter_config(input logic [COEF_W-1:0] gain, input logic [COEF_W-1:0] decay,
                                   input logic [LEVEL_W-1:0] floor_value);
      drain_results(SETTLE_CYCLES);
      write_reg(CSR_GAIN, CSR_DATA_W'(gain));
      write_reg(CSR_DECAY, CSR_DATA_W'(decay));
      write_reg(CSR_FLOOR, CSR_DATA_W'(floor_value));
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic test_basic_levels();
      send_item(REQ_SAMPLE, -16'sd32768, 1'b1);
      send_item(REQ_SAMPLE, 16'sd32767, 1'b1);
      send_item(REQ_SAMPLE, 16'sd0, 1'b1);
      send_item(REQ_SAMPLE, 16'sd1, 1'b1);
      send_item(REQ_CLEAR, 16'sd0, 1'b0);
      send_item(REQ_CLEAR, -16'sd1, 1'b1);
      send_item(REQ_SAMPLE, 16'sd1, 1'b0);
      send_item(REQ_CLEAR, 16'sd0, 1'b0);
      send_item(REQ_SAMPLE, -16'sd1, 1'b1);
      send_item(REQ_CLEAR, 16'sd0, 1'b0);
      send_item(REQ_SAMPLE, 16'sh5555, 1'b0);
      send_item(REQ_SAMPLE, 16'shAAAA, 1'b0);
      send_item(REQ_SAMPLE, 16'sd0, 1'b1);
   endtask

   task automatic test_zero_decay_and_gain();
      set_meter_config(16'hFFFF, 16'h0000, '0);
      send_item(REQ_SAMPLE, -16'sd32768, 1'b1);
      send_item(REQ_SAMPLE, 16'sd0, 1'b1);
      send_item(REQ_SAMPLE, 16'sd0, 1'b1);
      set_meter_config(16'h0000, 16'hFFFF, '0);
      send_item(REQ_SAMPLE, 16'sd32767, 1'b1);
      send_item(REQ_SAMPLE, -16'sd32768, 1'b1);
   endtask

   task automatic test_floor_above_full_scale();
      set_meter_config(GAIN_RESET, DECAY_RESET, FULL_SCALE + 17'd1);
      send_item(REQ_SAMPLE, -16'sd32768, 1'b1);
      send_item(REQ_SAMPLE, 16'sd100, 1'b1);
      set_meter_config(16'hFFFF, 16'hFFFF, '1);
      send_item(REQ_SAMPLE, 16'sd32767, 1'b1);
      set_meter_config(GAIN_RESET, DECAY_RESET, FULL_SCALE);
      send_item(REQ_SAMPLE, -16'sd32768, 1'b1);
      send_item(REQ_SAMPLE, 16'sd0, 1'b1);
   endtask

   task automatic test_overlong_chunk();
      set_meter_config(GAIN_RESET, DECAY_RESET, FLOOR_RESET);
      stall_pct = 30;
      for (int k = 0; k < MAX_CHUNK; k++) begin
         send_item(REQ_SAMPLE, SAMPLE_W'($urandom), 1'b0);
      end
      send_item(REQ_SAMPLE, SAMPLE_W'($urandom), 1'b0);
      send_item(REQ_SAMPLE, SAMPLE_W'($urandom), 1'b1);
      drain_results(SETTLE_CYCLES);
      stall_pct = 0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int loudness);
      int amp;
      int pick;
      case (loudness)
         0: return '0;
         1: return SAMPLE_W'($urandom);
         2: begin
            amp = 1 << $urandom_range(0, 14);
            pick = $urandom_range(0, 2 * amp);
            return SAMPLE_W'(pick - amp);
         end
         default: begin
            pick = $urandom_range(0, 2);
            return (pick == 0) ? -16'sd32768 : (pick == 1) ? 16'sd32767 : -16'sd32767;
         end
      endcase
   endfunction

   task automatic test_random_traffic(input int n_target, input int idle, input int stall,
                                      input bit pause_midway);
      int sent_here;
      int chunk_len;
      int loudness;
      int roll;
      bit paused;
      sender_idle_pct = idle;
      stall_pct = stall;
      sent_here = 0;
      paused = !pause_midway;
      while (sent_here < n_target) begin
         roll = $urandom_range(0, 99);
         chunk_len = (roll < 70) ? $urandom_range(1, 6) :
                     (roll < 95) ? $urandom_range(7, 32) : $urandom_range(33, 300);
         loudness = $urandom_range(0, 3);
         for (int k = 0; k < chunk_len; k++) begin
            if ($urandom_range(0, 99) < 4) begin
               send_item(REQ_CLEAR, SAMPLE_W'($urandom), 1'($urandom));
               sent_here++;
            end
            send_item(REQ_SAMPLE, pick_sample(loudness), k == chunk_len - 1);
            sent_here++;
            if (!paused && sent_here >= n_target / 2) begin
               paused = 1'b1;
               drain_results(0);
            end
         end
      end
      drain_results(SETTLE_CYCLES);
      sender_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_SAMPLE;
      req_sample <= '0;
      req_last <= 1'b0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_GAIN;
      csr_wdata <= '0;
      valid_high = 1'b0;
      error_count = 0;
      levels_checked = 0;
      items_sent = 0;
      chunk_ends = 0;
      clears_sent = 0;
      settings_used = 1;
      sender_idle_pct = 0;
      stall_pct = 0;
      cycle_count = 0;
      gain_q14 = GAIN_RESET;
      decay_q16 = DECAY_RESET;
      floor_q16 = FLOOR_RESET;
      square_total = '0;
      chunk_fill = 0;
      meter = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_levels();
      test_zero_decay_and_gain();
      test_floor_above_full_scale();
      test_overlong_chunk();
      set_meter_config(GAIN_RESET, DECAY_RESET, FLOOR_RESET);
      test_random_traffic(163, 0, 0, 1'b0);
      set_meter_config(16'hFFFF, 16'hFFFF, '0);
      test_random_traffic(163, 72, 0, 1'b0);
      set_meter_config(16'd16384, 16'd32768, 17'd1000);
      test_random_traffic(163, 0, 72, 1'b1);
      set_meter_config(COEF_W'($urandom), COEF_W'($urandom),
                       LEVEL_W'($urandom_range(0, 70000)));
      test_random_traffic(163, 13, 13, 1'b0);

      $display("Sent %0d transactions (%0d chunk ends, %0d clears); checked %0d levels.",
               items_sent, chunk_ends, clears_sent, levels_checked);
      $display("Used %0d register settings, including gain, decay and floor extremes.",
               settings_used);
      if (error_count == 0) begin
         $display("tb_rms_level_meter_unit: PASS");
      end else begin
         $display("tb_rms_level_meter_unit: FAIL");
      end
      $finish;
   end

endmodule
